/* sv/rpn_pkg.sv */
// Shared constants, codes and control structs of the RPN stack evaluator.
`default_nettype none
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int REQ_W       = 3;
  localparam int STAT_W      = 2;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [REQ_W-1:0] REQ_PUSH = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_ADD  = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_SUB  = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_MUL  = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_DIV  = REQ_W'(4);

  localparam logic [STAT_W-1:0] ST_OK      = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_UNDER   = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_OVER    = STAT_W'(2);
  localparam logic [STAT_W-1:0] ST_DIVZERO = STAT_W'(3);

  typedef struct packed {
    logic              capture;
    logic              alu_go;
    logic              div_start;
    logic              commit;
    logic              push;
    logic              pop;
    logic              clear;
    logic [STAT_W-1:0] status;
  } rpn_cmd_t;

  typedef struct packed {
    logic underflow;
    logic overflow;
    logic div_zero;
    logic div_done;
  } rpn_stat_t;

endpackage
`default_nettype wire

/* sv/rpn_req_if.sv */
// Token channel: one word per RPN token.
`default_nettype none
interface rpn_req_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, req_type, value, last, input ready);
  modport sink   (input valid, req_type, value, last, output ready);
endinterface
`default_nettype wire

/* sv/rpn_rsp_if.sv */
// Result channel: one word per evaluated token.
`default_nettype none
interface rpn_rsp_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [COUNT_W-1:0]       depth_now;
  logic [STAT_W-1:0]        status;
  logic                     done_res;

  modport source (output valid, top_value, depth_now, status, done_res, input ready);
  modport sink   (input valid, top_value, depth_now, status, done_res, output ready);
endinterface
`default_nettype wire

/* sv/rpn_div.sv */
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
`default_nettype none
module rpn_div import rpn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    dvs;
  logic                 neg;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;

  assign trial    = {rem, quo[DATA_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = neg ? (~quo + DATA_W'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
        dvs  <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
        neg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy) begin
        if (!diff[DATA_W]) begin
          rem <= diff[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done)
    else $error("divider did not go busy after start");

endmodule
`default_nettype wire

/* sv/rpn_ctrl.sv */
// Token sequencer: classifies each token, steps the datapath, owns result valid.
`default_nettype none
module rpn_ctrl import rpn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire logic [REQ_W-1:0] req_type,
  input  wire logic             last,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  input  wire rpn_stat_t        stat,
  output rpn_cmd_t              cmd
);

  typedef enum logic [1:0] {S_IDLE, S_OPER, S_DIVW, S_FINISH} state_t;

  state_t            st;
  logic [REQ_W-1:0]  op;
  logic              op_last;
  logic [STAT_W-1:0] status;
  logic              accept;
  logic              is_arith;

  assign req_ready = (st == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign is_arith  = op inside {REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV};

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.alu_go    = (st == S_OPER);
    cmd.div_start = (st == S_OPER) && (op == REQ_DIV) && !stat.div_zero;
    cmd.commit    = (st == S_FINISH) && (!rsp_valid || rsp_ready);
    cmd.push      = (op == REQ_PUSH) && (status == ST_OK);
    cmd.pop       = is_arith && (status == ST_OK);
    cmd.clear     = op_last;
    cmd.status    = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          if (accept) begin
            op      <= req_type;
            op_last <= last;
            if (req_type == REQ_PUSH) begin
              status <= stat.overflow ? ST_OVER : ST_OK;
              st     <= S_FINISH;
            end else if (req_type inside {REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV}) begin
              status <= stat.underflow ? ST_UNDER : ST_OK;
              st     <= stat.underflow ? S_FINISH : S_OPER;
            end else begin
              status <= ST_OK;
              st     <= S_FINISH;
            end
          end
        end
        S_OPER: begin
          if (op == REQ_DIV) begin
            if (stat.div_zero) begin
              status <= ST_DIVZERO;
              st     <= S_FINISH;
            end else begin
              st <= S_DIVW;
            end
          end else begin
            st <= S_FINISH;
          end
        end
        S_DIVW: begin
          if (stat.div_done) st <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd.commit) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
      if (cmd.commit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid && st == S_IDLE)
    else $error("commit did not produce a result word");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (st == S_FINISH) && rsp_valid && !rsp_ready |=> st == S_FINISH)
    else $error("finish left while result slot was full");

endmodule
`default_nettype wire

/* sv/rpn_dp.sv */
// Stack datapath: top register, stack RAM below it, ALU, divider, result register.
`default_nettype none
module rpn_dp import rpn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rpn_cmd_t          cmd,
  output rpn_stat_t              stat,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [DATA_W-1:0] value,
  output logic      [DATA_W-1:0] out_top,
  output logic     [COUNT_W-1:0] out_depth,
  output logic      [STAT_W-1:0] out_status,
  output logic                   out_done
);

  logic [DATA_W-1:0]  mem [STACK_DEPTH];
  logic [DATA_W-1:0]  top;
  logic [DATA_W-1:0]  left;
  logic [DATA_W-1:0]  res;
  logic [DATA_W-1:0]  value_q;
  logic [REQ_W-1:0]   op;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] below1;
  logic [COUNT_W-1:0] below2;
  logic [DATA_W-1:0]  quotient;
  logic               div_done;
  logic               mem_we;
  logic [DATA_W-1:0]  top_next;
  logic [COUNT_W-1:0] count_next;

  // top of stack lives in a register; the RAM holds the entries below it
  assign below1 = count - COUNT_W'(1);
  assign below2 = count - COUNT_W'(2);
  assign mem_we = cmd.commit && cmd.push && (count != '0);

  assign stat.underflow = count < COUNT_W'(2);
  assign stat.overflow  = count >= COUNT_W'(STACK_DEPTH);
  assign stat.div_zero  = (top == '0);
  assign stat.div_done  = div_done;

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (left),
    .divisor  (top),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[below1[ADDR_W-1:0]] <= top;
    left <= mem[below2[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= req_type;
      value_q <= value;
    end
    if (cmd.alu_go) begin
      case (op)
        REQ_ADD: res <= left + top;
        REQ_SUB: res <= left - top;
        REQ_MUL: res <= left * top;
        default: res <= res;
      endcase
    end
  end

  always_comb begin
    top_next   = top;
    count_next = count;
    if (cmd.push) begin
      top_next   = value_q;
      count_next = count + COUNT_W'(1);
    end else if (cmd.pop) begin
      top_next   = (op == REQ_DIV) ? quotient : res;
      count_next = below1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= cmd.clear ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top        <= top_next;
      out_top    <= (count_next != '0) ? top_next : '0;
      out_depth  <= count_next;
      out_status <= cmd.status;
      out_done   <= cmd.clear;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd.clear |=> count == '0)
    else $error("stack not emptied after last token");

  a_push: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd.push && !cmd.clear |=> count == $past(count) + COUNT_W'(1))
    else $error("push did not grow the stack by one");

endmodule
`default_nettype wire

/* sv/rpn_stack_evaluator.sv */
// Top level of the reverse Polish integer expression evaluator.
// Takes one token word at a time (push a signed 32-bit value, or add, subtract,
// multiply, divide the two top entries) on a 64-entry operand stack and returns
// exactly one result word per token: the new top, depth, status and a done flag
// on the token marked last, after which the stack is emptied. Tokens are taken
// one at a time; the next token is accepted while a result still waits on the
// output. A push, an unknown code or an operator that underflows goes from
// idle straight to the finish state; add, subtract, multiply and a divide by
// zero first pass the operate state, and divide also waits for the radix-2
// divider, which retires one quotient bit per cycle; a stalled output holds the
// token in its finish state. The stack RAM needs no clearing pass after reset;
// the block accepts tokens right away.
`default_nettype none
module rpn_stack_evaluator import rpn_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  rpn_req_if.sink   req,
  rpn_rsp_if.source rsp
);

  rpn_cmd_t          cmd;
  rpn_stat_t         stat;
  logic              req_ready;
  logic              rsp_valid;
  logic [DATA_W-1:0] out_top;

  assign req.ready     = req_ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.top_value = out_top;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .req_type  (req.req_type),
    .last      (req.last),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req.req_type),
    .value      (req.value),
    .out_top    (out_top),
    .out_depth  (rsp.depth_now),
    .out_status (rsp.status),
    .out_done   (rsp.done_res)
  );

endmodule
`default_nettype wire
